>>> src/foc_pkg.sv
// shared types, constants and helpers for the field-oriented current loop
package foc_pkg;

  // request and result payloads
  typedef struct packed {
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
    logic [15:0]        rotor_angle;
    logic signed [15:0] id_target;
    logic signed [15:0] iq_target;
    logic               speed_forward;
  } foc_req_t;

  typedef struct packed {
    logic [15:0]        compare_a;
    logic [15:0]        compare_b;
    logic [15:0]        compare_c;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;
  } foc_res_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_KP_D        = 3'd0,
    REG_KI_D_FWD    = 3'd1,
    REG_KI_D_OTHER  = 3'd2,
    REG_KP_Q        = 3'd3,
    REG_KI_Q        = 3'd4,
    REG_VOLT_LIMIT  = 3'd5,
    REG_PWM_PERIOD  = 3'd6
  } foc_reg_t;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_DEPTH_DEF = 1024;

  localparam int MUL_W      = 34;
  localparam int CORDIC_W   = 34;
  localparam int CORDIC_N   = 18;

  localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032875;
  localparam logic signed [MUL_W-1:0] INV_SQRT3_Q16 = 34'sd37838;
  localparam logic signed [MUL_W-1:0] SQRT3_Q16     = 34'sd113512;
  localparam logic signed [39:0] DUTY_MIN  = 40'sd85899346;
  localparam logic signed [39:0] DUTY_MAX  = 40'sd4209067950;
  localparam logic signed [39:0] DUTY_HALF = 40'sd2147483648;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10680862;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 to Q15, round half up, clamp to +-32767
  function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'sd32767;
    if (t < -34'sd32767) return -16'sd32767;
    return t[15:0];
  endfunction

  // symmetric clamp to +-lim
  function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

endpackage

>>> src/foc_mul.sv
// shared signed multiplier with registered product
module foc_mul (
  input  logic                              clk,
  input  logic signed [foc_pkg::MUL_W-1:0]   a,
  input  logic signed [foc_pkg::MUL_W-1:0]   b,
  output logic signed [2*foc_pkg::MUL_W-1:0] p
);
  import foc_pkg::*;

  // one product per cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> src/foc_cordic.sv
// iterative cordic giving sine and cosine of the quantized angle
module foc_cordic #(
  parameter int ANGLE_BITS       = foc_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = foc_pkg::TRIG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [15:0] sn,
  output logic signed [15:0] cs
);
  import foc_pkg::*;

  localparam int DL = $clog2(TRIG_TABLE_DEPTH);

  logic [ANGLE_BITS-1:0]      a;
  logic [ANGLE_BITS+DL-1:0]   wide;
  logic [DL-1:0]              idx;
  logic [31:0]                turn;
  logic signed [CORDIC_W-1:0] x, y, z, s_full, c_full;
  logic [1:0]                 quad;
  logic [4:0]                 i;
  logic                       busy;

  // angle to table index to turn fraction
  assign a    = angle[15 -: ANGLE_BITS];
  assign wide = {a, {DL{1'b0}}};
  assign idx  = wide[ANGLE_BITS+DL-1 : ANGLE_BITS];
  assign turn = {idx, {(32-DL){1'b0}}};

  // one rotation per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
        quad <= turn[31:30];
        x    <= CORDIC_K;
        y    <= '0;
        z    <= {4'b0000, turn[29:0]};
      end else if (busy) begin
        if (!z[CORDIC_W-1]) begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - atan_turn(i);
        end else begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + atan_turn(i);
        end
        if (i == 5'(CORDIC_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 5'd1;
        end
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (quad)
      2'd0:    begin s_full = y;  c_full = x;  end
      2'd1:    begin s_full = x;  c_full = -y; end
      2'd2:    begin s_full = -y; c_full = -x; end
      default: begin s_full = -x; c_full = y;  end
    endcase
  end

  assign sn = to_q15(s_full);
  assign cs = to_q15(c_full);

endmodule

>>> src/foc_current_loop_svpwm.sv
// top level: current loop sequencer, registers and result register
//
// Request channel: req_valid/req_stall with a foc_req_t payload; a request is
// taken when req_valid is high and req_stall low. req_stall is high while an
// item is being worked on.
// Result channel: res_valid/res_stall with a foc_res_t payload, one result per
// request. The result stays in its register until taken, and a new request
// can be taken meanwhile.
// Each item runs through 18 cordic rotations, a capture of sine and cosine
// and 24 steps on the single shared 34x34 multiplier. No new request is taken
// while one is being worked on; the next request can be taken in the cycle
// after the result is posted.
// If the result register is still full at the last step, the sequencer holds
// there until res_stall drops.
// Configuration: cfg_we with cfg_index and cfg_data, written by the user only
// while idle; the block does not enforce it. Synchronous reset (rst) restores
// the default gains, limit and period, clears both integrators and res_valid.
module foc_current_loop_svpwm #(
  parameter int ANGLE_BITS       = foc_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = foc_pkg::TRIG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  foc_pkg::foc_req_t req_data,
  output logic              res_valid,
  input  logic              res_stall,
  output foc_pkg::foc_res_t res_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import foc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROT  = 3'b010,
    S_MATH = 3'b100
  } state_t;

  typedef enum logic [4:0] {
    ST_ACS, ST_SSN, ST_BSN, ST_SCS, ST_BCS, ST_ASN, ST_ERR, ST_KID,
    ST_KPD, ST_KIQ, ST_KPQ, ST_VQ, ST_VDC, ST_VQS, ST_VDS, ST_VQC,
    ST_VB, ST_R3, ST_UVW, ST_DUTY, ST_CA, ST_CB, ST_CC, ST_OUT
  } step_t;

  state_t state;
  step_t  step;

  logic [31:0] kp_d, ki_d_fwd, ki_d_other, kp_q, ki_q;
  logic [14:0] voltage_limit;
  logic [16:0] pwm_period;

  foc_req_t               req;
  logic signed [17:0]     s_sum;
  logic signed [15:0]     sn, cs, c_sn, c_cs;
  logic                   c_done;
  logic                   c_start;
  logic signed [49:0]     acc_d, acc_q;
  logic signed [27:0]     err_d, err_q;
  logic signed [47:0]     integ_d, integ_q;
  logic signed [15:0]     vd, vq;
  logic signed [33:0]     valpha, vbeta;
  logic signed [35:0]     ua, ub, uc;
  logic [31:0]            duty_a, duty_b, duty_c;
  logic [15:0]            cmp_a, cmp_b;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  logic signed [63:0] lim, sum_i, out_c, integ_c;
  logic signed [49:0] id8, iq8, q_full;
  logic signed [51:0] r_full;
  logic signed [35:0] r3;
  logic signed [35:0] umax, umin;
  logic signed [39:0] offs, va, vb, vc, da, db, dc;
  logic [15:0]        cmp_sat;
  logic               res_free;
  logic               res_load;

  assign req_stall = (state != S_IDLE);
  assign c_start   = req_valid && !req_stall;
  assign res_free  = !(res_valid && res_stall);
  assign res_load  = (state == S_MATH) && (step == ST_OUT) && res_free;

  foc_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .angle (req_data.rotor_angle),
    .done  (c_done),
    .sn    (c_sn),
    .cs    (c_cs)
  );

  foc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      ST_ACS:  begin mul_a = MUL_W'(req.current_a); mul_b = MUL_W'(cs); end
      ST_SSN:  begin mul_a = MUL_W'(s_sum); mul_b = MUL_W'(sn); end
      ST_BSN:  begin mul_a = mul_p[MUL_W-1:0]; mul_b = INV_SQRT3_Q16; end
      ST_SCS:  begin mul_a = MUL_W'(s_sum); mul_b = MUL_W'(cs); end
      ST_BCS:  begin mul_a = mul_p[MUL_W-1:0]; mul_b = INV_SQRT3_Q16; end
      ST_ASN:  begin mul_a = MUL_W'(req.current_a); mul_b = MUL_W'(sn); end
      ST_KID:  begin
        mul_a = {2'b00, (req.speed_forward ? ki_d_fwd : ki_d_other)};
        mul_b = MUL_W'(err_d);
      end
      ST_KPD:  begin mul_a = {2'b00, kp_d}; mul_b = MUL_W'(err_d); end
      ST_KIQ:  begin mul_a = {2'b00, ki_q}; mul_b = MUL_W'(err_q); end
      ST_KPQ:  begin mul_a = {2'b00, kp_q}; mul_b = MUL_W'(err_q); end
      ST_VDC:  begin mul_a = MUL_W'(vd); mul_b = MUL_W'(cs); end
      ST_VQS:  begin mul_a = MUL_W'(vq); mul_b = MUL_W'(sn); end
      ST_VDS:  begin mul_a = MUL_W'(vd); mul_b = MUL_W'(sn); end
      ST_VQC:  begin mul_a = MUL_W'(vq); mul_b = MUL_W'(cs); end
      ST_R3:   begin mul_a = vbeta; mul_b = SQRT3_Q16; end
      ST_CA:   begin mul_a = {2'b00, duty_a}; mul_b = {17'd0, pwm_period}; end
      ST_CB:   begin mul_a = {2'b00, duty_b}; mul_b = {17'd0, pwm_period}; end
      ST_CC,
      ST_OUT:  begin mul_a = {2'b00, duty_c}; mul_b = {17'd0, pwm_period}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // datapath helpers around the product
  always_comb begin
    lim    = 64'({voltage_limit, 25'd0});
    sum_i  = mul_p[63:0] + 64'(step == ST_KPD ? integ_d : integ_q);
    integ_c = clamp_sym(sum_i, lim);
    out_c  = clamp_sym(mul_p[63:0] + 64'(step == ST_KIQ ? integ_d : integ_q), lim);
    id8    = (acc_d + 50'sd4194304) >>> 23;
    q_full = acc_q - {mul_p[33:0], 16'd0};
    iq8    = (q_full + 50'sd4194304) >>> 23;
    r_full = (mul_p[51:0] + 52'sd32768) >>> 16;
    r3     = r_full[35:0];
    umax = ua;
    if (ub > umax) umax = ub;
    if (uc > umax) umax = uc;
    umin = ua;
    if (ub < umin) umin = ub;
    if (uc < umin) umin = uc;
    offs = 40'(umax) + 40'(umin);
    va = DUTY_HALF - ((40'(ua) <<< 1) - offs);
    vb = DUTY_HALF - ((40'(ub) <<< 1) - offs);
    vc = DUTY_HALF - ((40'(uc) <<< 1) - offs);
    da = va < DUTY_MIN ? DUTY_MIN : (va > DUTY_MAX ? DUTY_MAX : va);
    db = vb < DUTY_MIN ? DUTY_MIN : (vb > DUTY_MAX ? DUTY_MAX : vb);
    dc = vc < DUTY_MIN ? DUTY_MIN : (vc > DUTY_MAX ? DUTY_MAX : vc);
    cmp_sat = mul_p[48] ? 16'hFFFF : mul_p[47:32];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_d          <= 32'd674310;
      ki_d_fwd      <= 32'd365072;
      ki_d_other    <= 32'd205729;
      kp_q          <= 32'd1181116;
      ki_q          <= 32'd202392;
      voltage_limit <= 15'd13107;
      pwm_period    <= 17'd4250;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_D:       kp_d          <= cfg_data;
        REG_KI_D_FWD:   ki_d_fwd      <= cfg_data;
        REG_KI_D_OTHER: ki_d_other    <= cfg_data;
        REG_KP_Q:       kp_q          <= cfg_data;
        REG_KI_Q:       ki_q          <= cfg_data;
        REG_VOLT_LIMIT: voltage_limit <= cfg_data[14:0];
        REG_PWM_PERIOD: pwm_period    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_ACS;
      res_valid <= 1'b0;
      integ_d   <= '0;
      integ_q   <= '0;
    end else begin
      // result flag: set on a new result, cleared once taken
      if (res_load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (c_start) begin
            req   <= req_data;
            s_sum <= 18'(req_data.current_a) + (18'(req_data.current_b) <<< 1);
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (c_done) begin
            sn    <= c_sn;
            cs    <= c_cs;
            step  <= ST_ACS;
            state <= S_MATH;
          end
        end
        S_MATH: begin
          if (step != ST_OUT) step <= step_t'(step + 5'd1);
          case (step)
            ST_SSN:  acc_d <= {mul_p[33:0], 16'd0};
            ST_SCS:  acc_d <= acc_d + mul_p[49:0];
            ST_ASN:  acc_q <= mul_p[49:0];
            ST_ERR: begin
              err_d <= (28'(req.id_target) <<< 8) - id8[27:0];
              err_q <= (28'(req.iq_target) <<< 8) - iq8[27:0];
            end
            ST_KPD:  integ_d <= integ_c[47:0];
            ST_KIQ:  vd <= 16'((out_c + 64'sd16777216) >>> 25);
            ST_KPQ:  integ_q <= integ_c[47:0];
            ST_VQ:   vq <= 16'((out_c + 64'sd16777216) >>> 25);
            ST_VQS:  valpha <= mul_p[33:0];
            ST_VDS:  valpha <= valpha - mul_p[33:0];
            ST_VQC:  vbeta <= mul_p[33:0];
            ST_VB:   vbeta <= vbeta + mul_p[33:0];
            ST_UVW: begin
              ua <= 36'(valpha) <<< 1;
              ub <= -36'(valpha) + r3;
              uc <= -36'(valpha) - r3;
            end
            ST_DUTY: begin
              duty_a <= da[31:0];
              duty_b <= db[31:0];
              duty_c <= dc[31:0];
            end
            ST_CB:   cmp_a <= cmp_sat;
            ST_CC:   cmp_b <= cmp_sat;
            ST_OUT: begin
              if (res_free) begin
                res_data.compare_a <= cmp_a;
                res_data.compare_b <= cmp_b;
                res_data.compare_c <= cmp_sat;
                res_data.volt_d    <= vd;
                res_data.volt_q    <= vq;
                state              <= S_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (rst)
    c_done |-> state == S_ROT) else $error("cordic finished outside rotation");
  a_req_starts_rot: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state == S_ROT) else $error("request not started");
  a_out_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_MATH && step == ST_OUT && res_free) |=> res_valid && state == S_IDLE)
    else $error("result not posted");
`endif

endmodule
